// ===== rtl/rebe_pkg.sv =====
package rebe_pkg;

	localparam int VAL_W      = 32;
	localparam int QUO_W      = 32;
	localparam int ORDER_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [ORDER_W-1:0]    ORDER_RST = ORDER_W'(16);
	localparam logic [CFG_DATA_W-1:0] COND_RST  = CFG_DATA_W'(65536);
	localparam logic [CFG_DATA_W-1:0] LEVEL_RST = CFG_DATA_W'(65536);

	localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_LOAD_X = 2'd2,
		CMD_START  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_B_ZERO = 2'd1,
		STATUS_SAT    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_MAC,
		MUL_BB,
		MUL_RLL,
		MUL_RHL,
		MUL_RHH,
		MUL_CN_LO,
		MUL_CN_HI
	} mul_op_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] value;
	} in_req_t;

	typedef struct packed {
		logic [31:0] error_bound;
		logic        is_acceptable;
		status_t     status;
	} out_rsp_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic    clr;
		logic    rd_en;
		logic    row_end;
		mul_op_t mul_op;
		logic    sq_load;
		logic    sq_step;
		logic    sq_store;
		logic    sq_sel;
		logic    div_load;
		logic    div_step;
		logic    res_load;
		status_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic nb_zero;
		logic sat;
	} dp_stat_t;

endpackage

// ===== rtl/rebe_datapath.sv =====
module rebe_datapath #(
	parameter int MAX_ORDER = 16,
	parameter int IDX_W     = 4,
	parameter int ACC_W     = 53,
	parameter int R_W       = 54,
	parameter int SR_W      = 113,
	parameter int RT_W      = 57,
	parameter int NUM_W     = 89
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rebe_pkg::in_req_t   req,
	input  logic                req_fire,
	input  rebe_pkg::cfg_wr_t   cfg,
	input  rebe_pkg::dp_cmd_t   cmd,
	input  logic [IDX_W-1:0]    rd_row,
	input  logic [IDX_W-1:0]    rd_col,
	output rebe_pkg::dp_stat_t  stat,
	output rebe_pkg::out_rsp_t  rsp
);

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = rebe_pkg::VAL_W;
	localparam int QW    = rebe_pkg::QUO_W;

	logic [VW-1:0] mat_mem [DEPTH];
	logic [VW-1:0] x_mem   [MAX_ORDER];
	logic [VW-1:0] b_mem   [MAX_ORDER];

	logic signed [VW-1:0] a_rd_q, x_rd_q, b_rd_q;
	logic [VW-1:0]        cond_q, level_q;
	logic                 mac_s1;
	rebe_pkg::mul_op_t    cur_op, op_s2;
	logic signed [32:0]   mul_a, mul_b;
	logic signed [65:0]   mul_p, prod_s2;
	logic [63:0]          prod_u;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [R_W-1:0]   rdiff;
	logic [R_W-1:0]          rmag, rmag_q;
	logic [VW-1:0]           bmag, bmag_q;
	logic [SR_W-1:0]         sr_q, sb_q;
	logic [NUM_W-1:0]        num_q;

	logic [2*RT_W-1:0] rad_q;
	logic [RT_W-1:0]   srem_q, root_q, nr_q, nb_q;
	logic [RT_W+1:0]   rem_nx, trial;
	logic              sq_ge;

	logic [RT_W-1:0] drem_q;
	logic [QW-1:0]   dlow_q, dq_q;
	logic [RT_W:0]   dnx, dden;
	logic            d_ge;

	logic            row_ok, col_ok, wr_a, wr_b, wr_x;
	logic [AW-1:0]   wa, ra;
	logic [IDX_W-1:0] wcol;
	rebe_pkg::out_rsp_t rsp_q;

	// store writes
	assign row_ok = int'(req.row) < MAX_ORDER;
	assign col_ok = int'(req.col) < MAX_ORDER;
	assign wr_a   = req_fire && req.cmd == rebe_pkg::CMD_LOAD_A && row_ok && col_ok;
	assign wr_b   = req_fire && req.cmd == rebe_pkg::CMD_LOAD_B && col_ok;
	assign wr_x   = req_fire && req.cmd == rebe_pkg::CMD_LOAD_X && col_ok;
	assign wa     = AW'(int'(req.row) * MAX_ORDER + int'(req.col));
	assign wcol   = IDX_W'(req.col);
	assign ra     = AW'(int'(rd_row) * MAX_ORDER + int'(rd_col));

	always_ff @(posedge clk) begin
		if (wr_a)
			mat_mem[wa] <= req.value;
		if (wr_b)
			b_mem[wcol] <= req.value;
		if (wr_x)
			x_mem[wcol] <= req.value;
		if (cmd.rd_en) begin
			a_rd_q <= mat_mem[ra];
			x_rd_q <= x_mem[rd_col];
			b_rd_q <= b_mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1  <= 1'b0;
			op_s2   <= rebe_pkg::MUL_NONE;
			cond_q  <= rebe_pkg::COND_RST;
			level_q <= rebe_pkg::LEVEL_RST;
		end else begin
			mac_s1 <= cmd.rd_en;
			op_s2  <= cur_op;
			if (cfg.we) begin
				unique case (cfg.idx)
					rebe_pkg::CFG_COND:  cond_q  <= cfg.data;
					rebe_pkg::CFG_LEVEL: level_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	// shared multiplier: row products while the read pipe runs, else the sequenced op
	assign cur_op = mac_s1 ? rebe_pkg::MUL_MAC : cmd.mul_op;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cur_op)
			rebe_pkg::MUL_MAC: begin
				mul_a = {a_rd_q[VW-1], a_rd_q};
				mul_b = {x_rd_q[VW-1], x_rd_q};
			end
			rebe_pkg::MUL_BB: begin
				mul_a = {1'b0, bmag_q};
				mul_b = {1'b0, bmag_q};
			end
			rebe_pkg::MUL_RLL: begin
				mul_a = {1'b0, rmag_q[31:0]};
				mul_b = {1'b0, rmag_q[31:0]};
			end
			rebe_pkg::MUL_RHL: begin
				mul_a = 33'(rmag_q[R_W-1:32]);
				mul_b = {1'b0, rmag_q[31:0]};
			end
			rebe_pkg::MUL_RHH: begin
				mul_a = 33'(rmag_q[R_W-1:32]);
				mul_b = 33'(rmag_q[R_W-1:32]);
			end
			rebe_pkg::MUL_CN_LO: begin
				mul_a = {1'b0, cond_q};
				mul_b = {1'b0, nr_q[31:0]};
			end
			rebe_pkg::MUL_CN_HI: begin
				mul_a = {1'b0, cond_q};
				mul_b = 33'(nr_q[RT_W-1:32]);
			end
			default: ;
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign prod_u = prod_s2[63:0];

	always_ff @(posedge clk)
		prod_s2 <= mul_p;

	assign rdiff = R_W'(b_rd_q) - R_W'(acc_q);
	assign rmag  = rdiff[R_W-1] ? R_W'(-rdiff) : R_W'(rdiff);
	assign bmag  = b_rd_q[VW-1] ? VW'(-b_rd_q) : VW'(b_rd_q);

	// accumulate the registered product according to its op tag
	always_ff @(posedge clk) begin
		case (op_s2)
			rebe_pkg::MUL_MAC:   acc_q <= acc_q + ACC_W'(prod_s2 >>> 16);
			rebe_pkg::MUL_BB:    sb_q  <= sb_q + SR_W'(prod_u);
			rebe_pkg::MUL_RLL:   sr_q  <= sr_q + SR_W'(prod_u);
			rebe_pkg::MUL_RHL:   sr_q  <= sr_q + SR_W'({prod_u, 33'b0});
			rebe_pkg::MUL_RHH:   sr_q  <= sr_q + SR_W'({prod_u, 64'b0});
			rebe_pkg::MUL_CN_LO: num_q <= NUM_W'(prod_u);
			rebe_pkg::MUL_CN_HI: num_q <= num_q + NUM_W'({prod_u, 32'b0});
			default: ;
		endcase
		if (cmd.row_end) begin
			rmag_q <= rmag;
			bmag_q <= bmag;
			acc_q  <= '0;
		end
		if (cmd.clr) begin
			acc_q <= '0;
			sr_q  <= '0;
			sb_q  <= '0;
		end
	end

	// digit-by-digit square root, two radicand bits a step
	assign rem_nx = {srem_q, rad_q[2*RT_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign sq_ge  = rem_nx >= trial;

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			rad_q  <= cmd.sq_sel ? (2*RT_W)'(sb_q) : (2*RT_W)'(sr_q);
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sq_step) begin
			rad_q  <= rad_q << 2;
			srem_q <= sq_ge ? RT_W'(rem_nx - trial) : RT_W'(rem_nx);
			root_q <= {root_q[RT_W-2:0], sq_ge};
		end
		if (cmd.sq_store) begin
			if (cmd.sq_sel)
				nb_q <= root_q;
			else
				nr_q <= root_q;
		end
	end

	// restoring division, one quotient bit a step
	assign dden = {1'b0, nb_q};
	assign dnx  = {drem_q, dlow_q[QW-1]};
	assign d_ge = dnx >= dden;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			drem_q <= num_q[NUM_W-1:QW];
			dlow_q <= num_q[QW-1:0];
			dq_q   <= '0;
		end else if (cmd.div_step) begin
			drem_q <= d_ge ? RT_W'(dnx - dden) : RT_W'(dnx);
			dlow_q <= dlow_q << 1;
			dq_q   <= {dq_q[QW-2:0], d_ge};
		end
	end

	assign stat.nb_zero = nb_q == '0;
	assign stat.sat     = drem_q >= nb_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				rebe_pkg::STATUS_OK: begin
					rsp_q.error_bound   <= dq_q;
					rsp_q.is_acceptable <= dq_q <= level_q;
					rsp_q.status        <= rebe_pkg::STATUS_OK;
				end
				rebe_pkg::STATUS_SAT: begin
					rsp_q.error_bound   <= '1;
					rsp_q.is_acceptable <= 1'b0;
					rsp_q.status        <= rebe_pkg::STATUS_SAT;
				end
				default: begin
					rsp_q.error_bound   <= '0;
					rsp_q.is_acceptable <= 1'b0;
					rsp_q.status        <= rebe_pkg::STATUS_B_ZERO;
				end
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/rebe_ctrl.sv =====
module rebe_ctrl #(
	parameter int MAX_ORDER = 16,
	parameter int IDX_W     = 4,
	parameter int CNT_W     = 5,
	parameter int RT_W      = 57
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rebe_pkg::in_req_t   req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  rebe_pkg::cfg_wr_t   cfg,
	output rebe_pkg::dp_cmd_t   cmd,
	output logic [IDX_W-1:0]    rd_row,
	output logic [IDX_W-1:0]    rd_col,
	input  rebe_pkg::dp_stat_t  stat
);

	localparam int QW    = rebe_pkg::QUO_W;
	localparam int STP_W = $clog2(((RT_W > QW) ? RT_W : QW) + 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_MAC, ST_W1, ST_W2, ST_ROW_END, ST_BB, ST_RLL, ST_RHL, ST_RHH,
		ST_SUM_WAIT, ST_SQ_LOAD, ST_SQ_STEP, ST_SQ_STORE, ST_CHECK_NB,
		ST_CN_LO, ST_CN_HI, ST_NUM_WAIT, ST_DIV_LOAD, ST_DIV_CHECK, ST_DIV_STEP,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [IDX_W-1:0]                i_q, j_q;
	logic [STP_W-1:0]                stp_q;
	logic                            sel_q;
	rebe_pkg::status_t               res_q;
	logic [rebe_pkg::ORDER_W-1:0]    order_q;
	logic                            rsp_valid_q;
	logic [CNT_W-1:0]                n_use;
	logic                            last_i, last_j, start, emit;

	assign n_use  = (int'(order_q) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(order_q);
	assign last_i = CNT_W'(i_q) + CNT_W'(1) == n_use;
	assign last_j = CNT_W'(j_q) + CNT_W'(1) == n_use;
	assign start  = req_valid && req.cmd == rebe_pkg::CMD_START;
	assign emit   = !rsp_valid_q || rsp_ready;

	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rd_row    = i_q;
	assign rd_col    = j_q;

	always_comb begin
		cmd         = '0;
		cmd.sq_sel  = sel_q;
		cmd.res_sel = res_q;
		unique case (state_q)
			ST_IDLE:     cmd.clr      = start;
			ST_MAC:      cmd.rd_en    = 1'b1;
			ST_ROW_END:  cmd.row_end  = 1'b1;
			ST_BB:       cmd.mul_op   = rebe_pkg::MUL_BB;
			ST_RLL:      cmd.mul_op   = rebe_pkg::MUL_RLL;
			ST_RHL:      cmd.mul_op   = rebe_pkg::MUL_RHL;
			ST_RHH:      cmd.mul_op   = rebe_pkg::MUL_RHH;
			ST_SQ_LOAD:  cmd.sq_load  = 1'b1;
			ST_SQ_STEP:  cmd.sq_step  = 1'b1;
			ST_SQ_STORE: cmd.sq_store = 1'b1;
			ST_CN_LO:    cmd.mul_op   = rebe_pkg::MUL_CN_LO;
			ST_CN_HI:    cmd.mul_op   = rebe_pkg::MUL_CN_HI;
			ST_DIV_LOAD: cmd.div_load = 1'b1;
			ST_DIV_STEP: cmd.div_step = 1'b1;
			ST_FINISH:   cmd.res_load = emit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			stp_q       <= '0;
			sel_q       <= 1'b0;
			res_q       <= rebe_pkg::STATUS_OK;
			order_q     <= rebe_pkg::ORDER_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.we && cfg.idx == rebe_pkg::CFG_ORDER)
				order_q <= cfg.data[rebe_pkg::ORDER_W-1:0];
			if (state_q == ST_FINISH && emit)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						i_q     <= '0;
						j_q     <= '0;
						sel_q   <= 1'b0;
						state_q <= (n_use == '0) ? ST_SUM_WAIT : ST_MAC;
					end
				end
				ST_MAC: begin
					if (last_j)
						state_q <= ST_W1;
					else
						j_q <= j_q + IDX_W'(1);
				end
				ST_W1:      state_q <= ST_W2;
				ST_W2:      state_q <= ST_ROW_END;
				ST_ROW_END: state_q <= ST_BB;
				ST_BB:      state_q <= ST_RLL;
				ST_RLL:     state_q <= ST_RHL;
				ST_RHL:     state_q <= ST_RHH;
				ST_RHH: begin
					if (last_i) begin
						state_q <= ST_SUM_WAIT;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						j_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_SUM_WAIT: state_q <= ST_SQ_LOAD;
				ST_SQ_LOAD: begin
					stp_q   <= STP_W'(RT_W - 1);
					state_q <= ST_SQ_STEP;
				end
				ST_SQ_STEP: begin
					if (stp_q == '0)
						state_q <= ST_SQ_STORE;
					else
						stp_q <= stp_q - STP_W'(1);
				end
				ST_SQ_STORE: begin
					if (sel_q) begin
						state_q <= ST_CHECK_NB;
					end else begin
						sel_q   <= 1'b1;
						state_q <= ST_SQ_LOAD;
					end
				end
				ST_CHECK_NB: begin
					if (stat.nb_zero) begin
						res_q   <= rebe_pkg::STATUS_B_ZERO;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_CN_LO;
					end
				end
				ST_CN_LO:    state_q <= ST_CN_HI;
				ST_CN_HI:    state_q <= ST_NUM_WAIT;
				ST_NUM_WAIT: state_q <= ST_DIV_LOAD;
				ST_DIV_LOAD: state_q <= ST_DIV_CHECK;
				ST_DIV_CHECK: begin
					if (stat.sat) begin
						res_q   <= rebe_pkg::STATUS_SAT;
						state_q <= ST_FINISH;
					end else begin
						res_q   <= rebe_pkg::STATUS_OK;
						stp_q   <= STP_W'(QW - 1);
						state_q <= ST_DIV_STEP;
					end
				end
				ST_DIV_STEP: begin
					if (stp_q == '0)
						state_q <= ST_FINISH;
					else
						stp_q <= stp_q - STP_W'(1);
				end
				ST_FINISH: begin
					// hold the result until the output register is free
					if (emit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/residual_error_bound_estimator_unit.sv =====
// Load requests (A, b, xhat elements, signed Q16.16) are taken one per cycle whenever the
// unit is idle; a start request then occupies it until its result enters the output register.
// The root width RT_W is 57 at MAX_ORDER 16. A zero norm of b skips the product and the
// divide, a saturated bound skips the 32 divide steps, and the finish waits while an earlier
// result is still unread. The time is set by the single shared 33x33 multiplier, which runs
// one row product per cycle and four squaring steps per row, and by the two bit-serial square
// roots and the 32-step divider. The result waits in an output register, so loads continue
// while it is unread.
module residual_error_bound_estimator_unit #(
	parameter int MAX_ORDER = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  rebe_pkg::in_req_t                   req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output rebe_pkg::out_rsp_t                  rsp,
	input  logic                                cfg_we,
	input  logic [rebe_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rebe_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CNT_W = $clog2(MAX_ORDER + 1);
	localparam int ACC_W = 2 * rebe_pkg::VAL_W - 16 + CNT_W;
	localparam int R_W   = ACC_W + 1;
	localparam int SR_W  = 2 * R_W + CNT_W;
	localparam int RT_W  = (SR_W + 1) / 2;
	localparam int NUM_W = rebe_pkg::QUO_W + RT_W;

	rebe_pkg::cfg_wr_t  cfg;
	rebe_pkg::dp_cmd_t  cmd;
	rebe_pkg::dp_stat_t stat;
	logic [IDX_W-1:0]   rd_row, rd_col;
	logic               req_fire;

	assign cfg.we    = cfg_we;
	assign cfg.idx   = cfg_idx;
	assign cfg.data  = cfg_data;
	assign req_fire  = req_valid && req_ready;

	rebe_ctrl #(
		.MAX_ORDER (MAX_ORDER),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W),
		.RT_W      (RT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg       (cfg),
		.cmd       (cmd),
		.rd_row    (rd_row),
		.rd_col    (rd_col),
		.stat      (stat)
	);

	rebe_datapath #(
		.MAX_ORDER (MAX_ORDER),
		.IDX_W     (IDX_W),
		.ACC_W     (ACC_W),
		.R_W       (R_W),
		.SR_W      (SR_W),
		.RT_W      (RT_W),
		.NUM_W     (NUM_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_fire (req_fire),
		.cfg      (cfg),
		.cmd      (cmd),
		.rd_row   (rd_row),
		.rd_col   (rd_col),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/rebe_checker.sv =====
module rebe_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input rebe_pkg::in_req_t                   req,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input rebe_pkg::out_rsp_t                  rsp,
	input logic                                cfg_we,
	input logic [rebe_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input logic [rebe_pkg::CFG_DATA_W-1:0]     cfg_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.cmd == rebe_pkg::CMD_START |=> !req_ready)
		else $error("request taken during computation");

	a_bzero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == rebe_pkg::STATUS_B_ZERO
		|-> rsp.error_bound == '0 && !rsp.is_acceptable)
		else $error("zero b norm with nonzero bound");

	a_sat_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == rebe_pkg::STATUS_SAT
		|-> rsp.error_bound == '1 && !rsp.is_acceptable)
		else $error("saturated bound not all ones");

	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_acceptable |-> rsp.status == rebe_pkg::STATUS_OK)
		else $error("acceptable flag on an error status");

endmodule

bind residual_error_bound_estimator_unit rebe_checker u_rebe_checker (.*);
